// ===== rtl/rcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Raised-cosine pulse evaluator package
// Shared fixed-point constants, configuration register indexes and the
// constant tables of the Taylor-series sine evaluation.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int TIME_FRAC_BITS = 12;
  localparam int OUT_FRAC_BITS  = 14;
  localparam int QB             = 30;

  localparam logic [31:0] PI_Q     = 32'd3373259426;
  localparam logic [30:0] PI4_Q    = 31'd843314857;
  localparam logic [30:0] ONE_Q    = 31'h4000_0000;
  localparam logic [12:0] ROLL_MAX = 13'd4096;

  localparam int HSTEPS    = 6;
  localparam int SIN_LAT   = 3 + 3 * HSTEPS + 2;
  localparam int DIV_QBITS = 34;
  localparam int DIV_LAT   = 1 + DIV_QBITS;

  localparam logic CFG_ROLLOFF   = 1'b0;
  localparam logic CFG_NEAR_ZERO = 1'b1;

  // Horner divisors of the odd Taylor series, from the x^13 term down.
  function automatic logic [7:0] horner_div(input int k);
    logic [7:0] d;
    unique case (k)
      0:       d = 8'd156;
      1:       d = 8'd110;
      2:       d = 8'd72;
      3:       d = 8'd42;
      4:       d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), used for division by reciprocal multiplication.
  function automatic logic [29:0] horner_recip(input int k);
    logic [29:0] m;
    unique case (k)
      0:       m = 30'd27531841;
      1:       m = 30'd39045157;
      2:       m = 30'd59652323;
      3:       m = 30'd102261126;
      4:       m = 30'd214748364;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcp_sin.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined sine of a half-turn phase
// Folds a Q30 phase into a quarter turn, then evaluates the Taylor series in
// Horner form, three stages per term, and clamps the magnitude to 1.0.
// ----------------------------------------------------------------------------
module rcp_sin (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] phase_i,
  output logic [30:0] mag_o,
  output logic        neg_o
);

  localparam int H = rcp_pkg::HSTEPS;

  logic [29:0] fold_q;
  logic        n1_q;
  logic [30:0] th2_q;
  logic        n2_q;
  logic [31:0] x2_q;
  logic [30:0] th3_q;
  logic        n3_q;

  logic [29:0] fold_d;
  logic [61:0] thp;
  logic [61:0] x2p;

  always_comb begin
    if (phase_i[29:0] > 30'h2000_0000) begin
      fold_d = 30'(rcp_pkg::ONE_Q - {1'b0, phase_i[29:0]});
    end else begin
      fold_d = phase_i[29:0];
    end
  end

  assign thp = {30'b0, rcp_pkg::PI_Q} * {32'b0, fold_q};
  assign x2p = {31'b0, th2_q} * {31'b0, th2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
      n1_q   <= phase_i[30];
      th2_q  <= thp[60:30];
      n2_q   <= n1_q;
      x2_q   <= x2p[61:30];
      th3_q  <= th2_q;
      n3_q   <= n2_q;
    end
  end

  // Horner stages: multiply by x^2, divide by the constant, subtract from one.
  logic [31:0] va_q [H];
  logic [31:0] xa_q [H];
  logic [30:0] ta_q [H];
  logic        na_q [H];
  logic [29:0] q0_q [H];
  logic [31:0] vb_q [H];
  logic [31:0] xb_q [H];
  logic [30:0] tb_q [H];
  logic        nb_q [H];
  logic [30:0] rc_q [H];
  logic [31:0] xc_q [H];
  logic [30:0] tc_q [H];
  logic        nc_q [H];

  for (genvar k = 0; k < H; k++) begin : g_step
    logic [31:0] x_in;
    logic [30:0] r_in;
    logic [30:0] t_in;
    logic        n_in;
    logic [62:0] pa;
    logic [61:0] pb;
    logic [37:0] back;
    logic [31:0] rem;
    logic        bump;
    logic [30:0] quo;

    if (k == 0) begin : g_first
      assign x_in = x2_q;
      assign r_in = rcp_pkg::ONE_Q;
      assign t_in = th3_q;
      assign n_in = n3_q;
    end else begin : g_next
      assign x_in = xc_q[k-1];
      assign r_in = rc_q[k-1];
      assign t_in = tc_q[k-1];
      assign n_in = nc_q[k-1];
    end

    assign pa   = {31'b0, x_in} * {32'b0, r_in};
    assign pb   = {30'b0, va_q[k]} * {32'b0, rcp_pkg::horner_recip(k)};
    assign back = {8'b0, q0_q[k]} * {30'b0, rcp_pkg::horner_div(k)};
    // The reciprocal estimate is low by at most one.
    assign rem  = vb_q[k] - back[31:0];
    assign bump = rem >= {24'b0, rcp_pkg::horner_div(k)};
    assign quo  = {1'b0, q0_q[k]} + {30'b0, bump};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        va_q[k] <= pa[61:30];
        xa_q[k] <= x_in;
        ta_q[k] <= t_in;
        na_q[k] <= n_in;
        q0_q[k] <= pb[61:32];
        vb_q[k] <= va_q[k];
        xb_q[k] <= xa_q[k];
        tb_q[k] <= ta_q[k];
        nb_q[k] <= na_q[k];
        rc_q[k] <= rcp_pkg::ONE_Q - quo;
        xc_q[k] <= xb_q[k];
        tc_q[k] <= tb_q[k];
        nc_q[k] <= nb_q[k];
      end
    end
  end

  logic [61:0] sp;
  logic [31:0] s_q;
  logic        ns_q;
  logic [30:0] mag_q;
  logic        neg_q;

  assign sp = {31'b0, tc_q[H-1]} * {31'b0, rc_q[H-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= sp[61:30];
      ns_q  <= nc_q[H-1];
      mag_q <= (s_q > {1'b0, rcp_pkg::ONE_Q}) ? rcp_pkg::ONE_Q : s_q[30:0];
      neg_q <= ns_q;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule
`default_nettype wire

// ===== rtl/rcp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides (num << 30) by den, one quotient bit per stage, with a flag for
// quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module rcp_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] num_i,
  input  logic [38:0] den_i,
  output logic [33:0] quo_o,
  output logic        ovf_o
);

  localparam int N = rcp_pkg::DIV_QBITS;

  logic [38:0] r_q   [N+1];
  logic [38:0] d_q   [N+1];
  logic [3:0]  lo_q  [N+1];
  logic [33:0] q_q   [N+1];
  logic        ovf_q [N+1];

  logic [38:0] r0;

  // The upper dividend bits form the starting remainder; if they already
  // reach the divisor the quotient overflows.
  assign r0 = {12'b0, num_i[30:4]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r0;
      d_q[0]   <= den_i;
      lo_q[0]  <= num_i[3:0];
      q_q[0]   <= '0;
      ovf_q[0] <= r0 >= den_i;
    end
  end

  for (genvar j = 1; j <= N; j++) begin : g_bit
    logic [39:0] rs;
    logic        ge;

    assign rs = {r_q[j-1], lo_q[j-1][3]};
    assign ge = rs >= {1'b0, d_q[j-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? 39'(rs - {1'b0, d_q[j-1]}) : rs[38:0];
        d_q[j]   <= d_q[j-1];
        lo_q[j]  <= {lo_q[j-1][2:0], 1'b0};
        q_q[j]   <= {q_q[j-1][32:0], ge};
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = q_q[N];
  assign ovf_o = ovf_q[N];

endmodule
`default_nettype wire

// ===== rtl/raised_cosine_pulse_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Raised-cosine pulse evaluator
// Returns sinc(t) * cos(pi a t) / (1 - (2 a t)^2) in Q1.14 for a Q3.12 time.
// ----------------------------------------------------------------------------
// One evaluation per clock cycle while the input is ready. A result can be
// taken once its time offset has passed, in order, the four setup stages,
// the Horner sine pipelines, the bit-per-stage dividers, the final product
// registers and the output register. A two-entry output buffer keeps
// accepting while one result waits; the input stalls only once both
// entries are full. Write rolloff (index 0) and near_zero_limit (index 1)
// only while no transaction is in flight.
module raised_cosine_pulse_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] time_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pulse_value_o
);

  localparam int NSTG = 4 + rcp_pkg::SIN_LAT + rcp_pkg::DIV_LAT + 2;
  localparam int SH   = rcp_pkg::QB - rcp_pkg::OUT_FRAC_BITS;

  typedef struct packed {
    logic [38:0] den_mag;
    logic        den_neg;
    logic [35:0] pit;
    logic        sinc_zero;
    logic        cos_zero;
  } sin_side_t;

  typedef struct packed {
    logic sinc_zero;
    logic cos_zero;
    logic sinc_neg;
    logic cos_neg;
  } div_side_t;

  // Configuration.
  logic [12:0] rolloff_q;
  logic [7:0]  nzl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rolloff_q <= 13'd1024;
      nzl_q     <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcp_pkg::CFG_ROLLOFF:   rolloff_q <= cfg_wdata_i;
        rcp_pkg::CFG_NEAR_ZERO: nzl_q     <= cfg_wdata_i[7:0];
        default:                nzl_q     <= nzl_q;
      endcase
    end
  end

  logic [25:0] lim;
  logic [12:0] alpha;
  assign lim   = {nzl_q, 18'b0};
  assign alpha = (rolloff_q > rcp_pkg::ROLL_MAX) ? rcp_pkg::ROLL_MAX : rolloff_q;

  logic en;
  logic skid_valid_q;
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  logic vld_q [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Setup stages: magnitude, products, denominator.
  logic [15:0] mag_d;
  logic [15:0] mag1_q;
  logic [27:0] prod2_q;
  logic [35:0] pit2_q;
  logic [30:0] sph2_q;
  logic [38:0] sq3_q;
  logic [30:0] cph3_q;
  logic [35:0] pit3_q;
  logic [30:0] sph3_q;
  logic        sz3_q;
  logic [38:0] den4_q;
  logic        dneg4_q;
  logic        cz4_q;
  logic [35:0] pit4_q;
  logic [30:0] sph4_q;
  logic [30:0] cph4_q;
  logic        sz4_q;

  logic [28:0] prodw;
  logic [47:0] pitw;
  logic [55:0] sqw;
  logic        dneg;
  logic [38:0] dmag;

  assign mag_d = time_offset_i[15] ? (~$unsigned(time_offset_i) + 16'd1)
                                   : $unsigned(time_offset_i);
  assign prodw = {16'b0, alpha} * {13'b0, mag1_q};
  assign pitw  = {16'b0, rcp_pkg::PI_Q} * {32'b0, mag1_q};
  assign sqw   = {28'b0, prod2_q} * {28'b0, prod2_q};
  assign dneg  = sq3_q > {8'b0, rcp_pkg::ONE_Q};
  assign dmag  = dneg ? (sq3_q - {8'b0, rcp_pkg::ONE_Q}) : ({8'b0, rcp_pkg::ONE_Q} - sq3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q  <= mag_d;
      prod2_q <= prodw[27:0];
      pit2_q  <= 36'(pitw >> rcp_pkg::TIME_FRAC_BITS);
      sph2_q  <= 31'(mag1_q) << (rcp_pkg::QB - rcp_pkg::TIME_FRAC_BITS);
      sq3_q   <= 39'(sqw >> (2 * rcp_pkg::TIME_FRAC_BITS - 8));
      // Cosine phase is a*t plus a quarter turn.
      cph3_q  <= 31'(34'(prod2_q) << (rcp_pkg::QB - 12 - rcp_pkg::TIME_FRAC_BITS))
                 + (rcp_pkg::ONE_Q >> 1);
      pit3_q  <= pit2_q;
      sph3_q  <= sph2_q;
      sz3_q   <= pit2_q <= {10'b0, lim};
      den4_q  <= dmag;
      dneg4_q <= dneg;
      cz4_q   <= dmag <= {13'b0, lim};
      pit4_q  <= pit3_q;
      sph4_q  <= sph3_q;
      cph4_q  <= cph3_q;
      sz4_q   <= sz3_q;
    end
  end

  // Sine pipelines with their side data.
  logic [30:0] smag;
  logic        sneg;
  logic [30:0] cmag;
  logic        cneg;

  rcp_sin u_sin_s (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (sph4_q),
    .mag_o   (smag),
    .neg_o   (sneg)
  );

  rcp_sin u_sin_c (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (cph4_q),
    .mag_o   (cmag),
    .neg_o   (cneg)
  );

  sin_side_t sd_q [rcp_pkg::SIN_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= '{den_mag: den4_q, den_neg: dneg4_q, pit: pit4_q,
                   sinc_zero: sz4_q, cos_zero: cz4_q};
      for (int i = 1; i < rcp_pkg::SIN_LAT; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  sin_side_t ss;
  assign ss = sd_q[rcp_pkg::SIN_LAT-1];

  // Dividers.
  logic [33:0] squo;
  logic        sovf;
  logic [33:0] cquo;
  logic        covf;

  rcp_div u_div_s (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (smag),
    .den_i ({3'b0, ss.pit}),
    .quo_o (squo),
    .ovf_o (sovf)
  );

  rcp_div u_div_c (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (cmag),
    .den_i (ss.den_mag),
    .quo_o (cquo),
    .ovf_o (covf)
  );

  div_side_t dd_q [rcp_pkg::DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= '{sinc_zero: ss.sinc_zero, cos_zero: ss.cos_zero,
                   sinc_neg: sneg, cos_neg: cneg ^ ss.den_neg};
      for (int i = 1; i < rcp_pkg::DIV_LAT; i++) dd_q[i] <= dd_q[i-1];
    end
  end

  div_side_t ds;
  assign ds = dd_q[rcp_pkg::DIV_LAT-1];

  // Term selection, product, rounding and saturation.
  localparam logic [33:0] COS_MAX = 34'({rcp_pkg::ONE_Q, 3'b0});

  logic [30:0] sm_q;
  logic [33:0] cm_q;
  logic        ng_q;
  logic [33:0] pm_q;
  logic        ngf_q;
  logic [30:0] sm_d;
  logic [33:0] cm_d;
  logic [64:0] pmw;

  always_comb begin
    if (ds.sinc_zero || sovf || squo > 34'(rcp_pkg::ONE_Q)) begin
      sm_d = rcp_pkg::ONE_Q;
    end else begin
      sm_d = squo[30:0];
    end
    if (ds.cos_zero) begin
      cm_d = 34'(rcp_pkg::PI4_Q);
    end else if (covf || cquo > COS_MAX) begin
      cm_d = COS_MAX;
    end else begin
      cm_d = cquo;
    end
  end

  assign pmw = {34'b0, sm_q} * {31'b0, cm_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q  <= sm_d;
      cm_q  <= cm_d;
      ng_q  <= (!ds.sinc_zero && ds.sinc_neg) ^ (!ds.cos_zero && ds.cos_neg);
      pm_q  <= pmw[63:30];
      ngf_q <= ng_q;
    end
  end

  logic [34:0] rsum;
  logic [34:0] rmag;
  logic [15:0] res;

  assign rsum = {1'b0, pm_q} + (35'd1 << (SH - 1));
  assign rmag = rsum >> SH;

  always_comb begin
    if (ngf_q) begin
      res = (rmag > 35'd32768) ? 16'h8000 : 16'(~rmag[15:0] + 16'd1);
    end else begin
      res = (rmag > 35'd32767) ? 16'h7FFF : rmag[15:0];
    end
  end

  // Output register with a skid entry.
  logic        out_valid_q;
  logic [15:0] out_q;
  logic [15:0] skid_q;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= vld_q[NSTG-1];
    end else if (vld_q[NSTG-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      if (vld_q[NSTG-1]) begin
        out_q <= res;
      end
    end else if (vld_q[NSTG-1]) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_value_o = $signed(out_q);

endmodule
`default_nettype wire

// ===== rtl/rcp_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Raised-cosine pulse evaluator port checker
// Watches the handshake and the output buffering seen at the ports.
// ----------------------------------------------------------------------------
module rcp_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] pulse_value_i
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pulse_value_i))
    else $error("result changed while stalled");

  // The input only stalls when the output buffer is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  a_stall_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input stall began without an output stall");

  a_stall_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> $past(out_valid_i && out_ready_i))
    else $error("input stall ended without a result transaction");

endmodule

bind raised_cosine_pulse_eval rcp_chk u_rcp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pulse_value_i (pulse_value_o)
);
`default_nettype wire

// ===== bench/raised_cosine_pulse_eval_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raised-cosine pulse checker
// Watches the configuration port and both channels, predicts the pulse value
// of every accepted time offset and compares it with the returned result.
// ----------------------------------------------------------------------------
module raised_cosine_pulse_eval_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] time_offset_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] pulse_value_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam longint unsigned OneQ = 64'd1 << rcp_pkg::QB;

  logic [12:0]        rolloff_q;
  logic [7:0]         near_zero_q;
  logic signed [15:0] expected_pulses[$];

  // sin(pi*x) with x in Q30 half turns, taken modulo two.
  function automatic longint sin_half(input longint unsigned phase);
    longint unsigned p, th, x2, r, s;
    longint unsigned divs[6];
    bit neg;
    divs = '{156, 110, 72, 42, 20, 6};
    p = phase & ((OneQ << 1) - 1);
    neg = 0;
    if (p >= OneQ) begin
      neg = 1;
      p = p - OneQ;
    end
    if (p > (OneQ >> 1)) p = OneQ - p;
    th = (64'(rcp_pkg::PI_Q) * p) >> rcp_pkg::QB;
    x2 = (th * th) >> rcp_pkg::QB;
    r = OneQ;
    for (int i = 0; i < 6; i++) r = OneQ - (((x2 * r) >> rcp_pkg::QB) / divs[i]);
    s = (th * r) >> rcp_pkg::QB;
    if (s > OneQ) s = OneQ;
    return neg ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [15:0] pulse_of(input logic signed [15:0] t,
                                           input logic [12:0] roll,
                                           input logic [7:0] nz);
    longint unsigned mag, lim, a, pi_t, sinc_mag, cos_mag, at, prod, q4;
    longint unsigned den_mag, prodmag, res;
    longint s, c, den;
    bit sinc_neg, cos_neg;
    mag = (t < 0) ? 64'(-int'(t)) : 64'(t);
    lim = 64'(nz) << (rcp_pkg::QB - 12);
    a = (roll > rcp_pkg::ROLL_MAX) ? 64'(rcp_pkg::ROLL_MAX) : 64'(roll);
    sinc_neg = 0;
    cos_neg = 0;
    pi_t = (64'(rcp_pkg::PI_Q) * mag) >> rcp_pkg::TIME_FRAC_BITS;
    if (pi_t <= lim) begin
      sinc_mag = OneQ;
    end else begin
      s = sin_half(mag << (rcp_pkg::QB - rcp_pkg::TIME_FRAC_BITS));
      sinc_neg = s < 0;
      sinc_mag = (64'(sinc_neg ? -s : s) << rcp_pkg::QB) / pi_t;
      if (sinc_mag > OneQ) sinc_mag = OneQ;
    end
    prod = a * mag;
    at = (prod << rcp_pkg::QB) >> (12 + rcp_pkg::TIME_FRAC_BITS);
    q4 = (4 * prod * prod) >> (2 * rcp_pkg::TIME_FRAC_BITS - 6);
    den = longint'(OneQ) - longint'(q4);
    den_mag = den < 0 ? 64'(-den) : 64'(den);
    if (den_mag <= lim) begin
      cos_mag = 64'(rcp_pkg::PI4_Q);
    end else begin
      c = sin_half(at + (OneQ >> 1));
      cos_neg = (c < 0) != (den < 0);
      cos_mag = (64'(c < 0 ? -c : c) << rcp_pkg::QB) / den_mag;
      if (cos_mag > (OneQ << 3)) cos_mag = OneQ << 3;
    end
    prodmag = (sinc_mag * cos_mag) >> rcp_pkg::QB;
    res = (prodmag + (64'd1 << (rcp_pkg::QB - rcp_pkg::OUT_FRAC_BITS - 1)))
          >> (rcp_pkg::QB - rcp_pkg::OUT_FRAC_BITS);
    if (sinc_neg != cos_neg) begin
      if (res > 32768) res = 32768;
      return 16'(65536 - res);
    end
    if (res > 32767) res = 32767;
    return 16'(res);
  endfunction

  assign pending_o = expected_pulses.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rolloff_q <= 13'd1024;
      near_zero_q <= 8'd4;
      fail_count_o <= 0;
      expected_pulses.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rcp_pkg::CFG_ROLLOFF) rolloff_q <= cfg_wdata_i;
        else near_zero_q <= cfg_wdata_i[7:0];
      end
      if (in_valid_i && in_ready_i)
        expected_pulses.push_back(pulse_of(time_offset_i, rolloff_q, near_zero_q));
      if (out_valid_i && out_ready_i) begin
        if (expected_pulses.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0d",
                   $time, pulse_value_i);
          fail_count_o <= fail_count_o + 1;
        end else if (expected_pulses[0] !== pulse_value_i) begin
          $display("%0t: pulse_value mismatch, expected %0d, actual %0d",
                   $time, expected_pulses[0], pulse_value_i);
          fail_count_o <= fail_count_o + 1;
          void'(expected_pulses.pop_front());
        end else begin
          void'(expected_pulses.pop_front());
        end
      end
    end
  end

endmodule

// ===== bench/raised_cosine_pulse_eval_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raised-cosine pulse testbench
// Drives directed and random time offsets under several roll-off and near-zero
// settings, idle and output-stall patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module raised_cosine_pulse_eval_tb;

  localparam int WatchdogLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = rcp_pkg::CFG_ROLLOFF;
  logic [12:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] time_offset_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] pulse_value_o;
  int                 pending;
  int                 fail_count;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  logic [12:0]        roll_now = 13'd1024;

  always #2 clk_i = ~clk_i;

  raised_cosine_pulse_eval dut (.*);

  raised_cosine_pulse_eval_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .time_offset_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pulse_value_i(pulse_value_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("raised_cosine_pulse_eval regression: fail");
        $finish;
      end
    end
  end

  task automatic send_offset(input logic [15:0] t);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    time_offset_i = t;
    #1;
    while (!in_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [12:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    if (idx == rcp_pkg::CFG_ROLLOFF) roll_now = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random offsets: full range, small magnitudes, points near integer times and
  // points near the cosine term's singularity at tau = 1 / (2 alpha).
  function automatic logic [15:0] random_offset();
    int a, sing;
    a = (roll_now > rcp_pkg::ROLL_MAX) ? int'(rcp_pkg::ROLL_MAX) : int'(roll_now);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return ($urandom_range(1) != 0) ? 16'(-int'($urandom_range(64)))
                                         : 16'($urandom_range(64));
      2: return 16'($urandom_range(4)) * 16'd4096 + 16'($urandom_range(8)) - 16'd4;
      default: begin
        sing = (a == 0) ? 32767 : (8388608 / a);
        if (sing > 32760) sing = 32760;
        sing = sing + $urandom_range(16) - 8;
        return ($urandom_range(1) != 0) ? 16'(-sing) : 16'(sing);
      end
    endcase
  endfunction

  initial begin
    logic [15:0] directed[$];
    logic [12:0] rolls[5];
    logic [7:0]  limits[5];
    directed = '{16'h0000, 16'h0001, 16'hffff, 16'h0002, 16'h1000, 16'hf000,
                 16'h2000, 16'he000, 16'h0800, 16'hf800, 16'h7fff, 16'h8000,
                 16'h8001, 16'h0555, 16'h3000, 16'h4000, 16'h5555, 16'haaaa,
                 16'h0004, 16'h0010};
    rolls = '{13'd1024, 13'd0, 13'd4096, 13'd8191, 13'd2048};
    limits = '{8'd4, 8'd0, 8'd255, 8'd0, 8'd20};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(rcp_pkg::CFG_ROLLOFF, rolls[ph]);
      write_cfg(rcp_pkg::CFG_NEAR_ZERO, {5'b0, limits[ph]});
      foreach (directed[i]) send_offset(directed[i]);
      for (int k = 0; k < 4; k++) begin
        idle_pct = (k == 1 || k == 3) ? ((k == 3) ? 6 : 73) : 0;
        stall_pct = (k == 2 || k == 3) ? ((k == 3) ? 6 : 73) : 0;
        for (int n = 0; n < 55; n++) send_offset(random_offset());
      end
      // Let every result come home before the next setting.
      drain();
    end
    write_cfg(rcp_pkg::CFG_ROLLOFF, 13'($urandom_range(4096)));
    write_cfg(rcp_pkg::CFG_NEAR_ZERO, 13'($urandom_range(255)));
    for (int n = 0; n < 60; n++) send_offset(random_offset());
    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (fail_count == 0) $display("raised_cosine_pulse_eval regression: pass");
    else $display("raised_cosine_pulse_eval regression: fail");
    $finish;
  end

endmodule
